### design/gf2rb_pkg.sv
// gf2rb_pkg: shared types and constants for the GF(2) rank block.
// No dependencies; used by the controller, datapath and top level.
package gf2rb_pkg;

    localparam int RANK_W = 6;
    localparam int IN_W   = 32;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch new word, start row prefetch
        logic step;     // reduce against current row, move down one bit
        logic insert;   // store remainder under current bit
        logic emit;     // publish rank, clear basis
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bit_set;  // working vector has current bit set
        logic row_ok;   // a basis row exists for current bit
        logic idx_zero; // current bit is bit 0
        logic out_busy; // result register full and stalled
    } dp_stat_t;

endpackage

### design/gf2_rank_xor_basis.sv
// gf2_rank_xor_basis: top level of the GF(2) rank block.
// Depends on gf2rb_pkg, gf2rb_ctrl and gf2rb_dp.
//
// Usage
//   Input channel (item_valid / item_stall, payload word, last): one binary
//   word per transaction. Bits at or above WORD_WIDTH are ignored. A set of
//   words ends with the transaction that has last = 1.
//   Output channel (rank_valid / rank_stall, payload rank_count): one
//   transaction per set, carrying the GF(2) rank of the set (modulo 64).
//   Each word is reduced against an incremental XOR basis, one basis row per
//   cycle from the top bit down; a nonzero remainder is stored under its
//   leading bit and bumps the rank.
// Timing
//   A word occupies the block for its accept in ST_IDLE, then a scan in
//   ST_SCAN that ends at an insert or at bit 0. The scan walks the basis
//   memory through its single registered read port, one row per cycle.
//   After the last word of a set the block enters ST_EMIT to publish the
//   rank, and waits there while the result slot is full and stalled.
//   item_stall is low only while the block is idle.
// Reset and backpressure
//   Reset empties the basis, zeroes the rank counter and drops rank_valid.
//   The result register holds while rank_stall is high; the next set's
//   words keep flowing, and only its own final rank waits for the slot.
module gf2_rank_xor_basis
#(
    parameter int WORD_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [gf2rb_pkg::IN_W-1:0]   word,
    input  logic                         last,
    output logic                         rank_valid,
    input  logic                         rank_stall,
    output logic [gf2rb_pkg::RANK_W-1:0] rank_count
);

    gf2rb_pkg::dp_cmd_t  cmd;
    gf2rb_pkg::dp_stat_t stat;

    gf2rb_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .last       (last),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    gf2rb_dp
    #(
        .WORD_WIDTH (WORD_WIDTH)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (word),
        .cmd        (cmd),
        .stat       (stat),
        .rank_valid (rank_valid),
        .rank_stall (rank_stall),
        .rank_count (rank_count)
    );

endmodule

### design/gf2rb_ctrl.sv
// gf2rb_ctrl: sequencing state machine for the GF(2) rank block.
// Depends on gf2rb_pkg (state_t, dp_cmd_t, dp_stat_t).
module gf2rb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                last,
    output logic                item_stall,
    input  gf2rb_pkg::dp_stat_t stat,
    output gf2rb_pkg::dp_cmd_t  cmd
);

    gf2rb_pkg::state_t state_reg, state_next;
    logic              last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            gf2rb_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    last_next  = last;
                    state_next = gf2rb_pkg::ST_SCAN;
                end
            end
            gf2rb_pkg::ST_SCAN:
            begin
                if (stat.bit_set && !stat.row_ok)
                begin
                    cmd.insert = 1'b1;
                    state_next = last_reg ? gf2rb_pkg::ST_EMIT : gf2rb_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.idx_zero)
                    begin
                        state_next = last_reg ? gf2rb_pkg::ST_EMIT : gf2rb_pkg::ST_IDLE;
                    end
                end
            end
            gf2rb_pkg::ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = gf2rb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gf2rb_pkg::ST_IDLE;
            end
        endcase
    end

    assign item_stall = (state_reg != gf2rb_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gf2rb_pkg::ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

### design/gf2rb_dp.sv
// gf2rb_dp: basis memory, working vector, bit index, rank counter and
// result register. Depends on gf2rb_pkg (dp_cmd_t, dp_stat_t, widths).
module gf2rb_dp
#(
    parameter int WORD_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [gf2rb_pkg::IN_W-1:0]   word,
    input  gf2rb_pkg::dp_cmd_t           cmd,
    output gf2rb_pkg::dp_stat_t          stat,
    output logic                         rank_valid,
    input  logic                         rank_stall,
    output logic [gf2rb_pkg::RANK_W-1:0] rank_count
);

    localparam int IW = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
    localparam logic [IW-1:0] TOP_IDX = IW'(WORD_WIDTH - 1);

    logic [WORD_WIDTH-1:0] rows_mem [WORD_WIDTH];
    logic [WORD_WIDTH-1:0] rd_reg;
    logic [WORD_WIDTH-1:0] v_reg, v_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         rd_addr;
    logic [WORD_WIDTH-1:0] row_valid_reg;
    logic [gf2rb_pkg::RANK_W-1:0] rank_reg;
    logic [gf2rb_pkg::RANK_W-1:0] rank_out_reg;
    logic                  rank_valid_reg;
    logic [WORD_WIDTH+gf2rb_pkg::IN_W-1:0] word_ext;

    // zero-extend, then keep the low WORD_WIDTH bits
    assign word_ext = {{WORD_WIDTH{1'b0}}, word};

    assign stat.bit_set  = v_reg[idx_reg];
    assign stat.row_ok   = row_valid_reg[idx_reg];
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.out_busy = rank_valid_reg && rank_stall;

    // prefetch the row one bit below the one under test, or the top row on load or at bit 0
    always_comb
    begin
        if (cmd.load || stat.idx_zero)
            rd_addr = TOP_IDX;
        else
            rd_addr = idx_reg - 1'b1;
    end

    always_comb
    begin
        v_next   = v_reg;
        idx_next = idx_reg;
        if (cmd.load)
        begin
            v_next   = word_ext[WORD_WIDTH-1:0];
            idx_next = TOP_IDX;
        end
        else if (cmd.step)
        begin
            if (stat.bit_set && stat.row_ok)
                v_next = v_reg ^ rd_reg;
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
            rows_mem[idx_reg] <= v_reg;
        rd_reg <= rows_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        idx_reg      <= idx_next;
        if (cmd.emit)
            rank_out_reg <= rank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            rank_reg       <= '0;
            rank_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                row_valid_reg <= '0;
                rank_reg      <= '0;
            end
            else if (cmd.insert)
            begin
                row_valid_reg[idx_reg] <= 1'b1;
                rank_reg               <= rank_reg + 1'b1;
            end
            if (cmd.emit)
                rank_valid_reg <= 1'b1;
            else if (!rank_stall)
                rank_valid_reg <= 1'b0;
        end
    end

    assign rank_valid = rank_valid_reg;
    assign rank_count = rank_out_reg;

endmodule

### design/gf2rb_chk.sv
// gf2rb_chk: port-level checks for gf2_rank_xor_basis, plus its bind.
// Depends on gf2rb_pkg for widths.
module gf2rb_chk
#(
    parameter int WORD_WIDTH = 32
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_stall,
    input logic                         rank_valid,
    input logic                         rank_stall,
    input logic [gf2rb_pkg::RANK_W-1:0] rank_count
);

    // rank can never exceed the vector dimension
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rank_valid |-> (7'(rank_count) <= 7'(WORD_WIDTH)))
        else $error("rank above word width");

    // an accepted word keeps the block busy the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input accepted while scan should be running");

    // a new rank is only published from the busy phase
    a_rank_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rank_valid) |-> $past(item_stall))
        else $error("rank published while idle");

    a_rank_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rank_valid && rank_stall) |=> rank_valid)
        else $error("rank dropped under stall");

    a_rank_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rank_valid && rank_stall) |=> $stable(rank_count))
        else $error("rank changed under stall");

endmodule

bind gf2_rank_xor_basis gf2rb_chk
#(
    .WORD_WIDTH (WORD_WIDTH)
)
u_gf2rb_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .rank_valid (rank_valid),
    .rank_stall (rank_stall),
    .rank_count (rank_count)
);
